@@ rtl/vpr_pkg.sv @@
// ----------------------------------------------------------------------------
// vpr_pkg
// Shared types and constants of the velocity PID ramp controller: default
// word format, configuration map, datapath operations, operand selects and
// the controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package vpr_pkg;

    localparam int DEF_WORD_WIDTH = 48;
    localparam int DEF_FRAC_BITS  = 32;

    // Configuration port: 64-bit data, registers on 8-byte addresses.
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 6;

    localparam logic [2:0] CFG_GAIN_P        = 3'd0;
    localparam logic [2:0] CFG_GAIN_I        = 3'd1;
    localparam logic [2:0] CFG_GAIN_D        = 3'd2;
    localparam logic [2:0] CFG_SAMPLE_PERIOD = 3'd3;
    localparam logic [2:0] CFG_VOLTAGE_LIMIT = 3'd4;
    localparam logic [2:0] CFG_CURRENT_LIMIT = 3'd5;
    localparam logic [2:0] CFG_RAMP_RATE     = 3'd6;
    localparam logic [2:0] CFG_TORQUE_MODE   = 3'd7;

    localparam logic [1:0] MODE_VOLTAGE = 2'd0;
    localparam logic [1:0] MODE_CURRENT = 2'd1;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_CLAMP,
        OP_RAMP,
        OP_MUL,
        OP_DIV,
        OP_COMMIT
    } t_op;

    typedef enum logic [3:0] {
        SRC_E,
        SRC_LE,
        SRC_IS,
        SRC_LD,
        SRC_P,
        SRC_T0,
        SRC_T1,
        SRC_DRV,
        SRC_GP,
        SRC_GI,
        SRC_GD,
        SRC_SP,
        SRC_RAMP,
        SRC_HALF
    } t_src;

    typedef enum logic [2:0] {
        DST_IS,
        DST_P,
        DST_T0,
        DST_T1,
        DST_DRV
    } t_dst;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL_P,
        ST_ADD_S,
        ST_MUL_H,
        ST_MUL_K,
        ST_MUL_I,
        ST_ADD_I,
        ST_CLP_I,
        ST_SUB_D,
        ST_MUL_D,
        ST_DIV_D,
        ST_ADD_1,
        ST_ADD_2,
        ST_CLP_O,
        ST_SUB_R,
        ST_DIV_R,
        ST_MUL_R,
        ST_RAMP,
        ST_COMMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic go;
        t_op  op;
        t_src src_a;
        t_src src_b;
        t_dst dst;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic out_free;
        logic is_voltage;
    } t_stat;

endpackage

@@ rtl/vpr_ctrl.sv @@
// ----------------------------------------------------------------------------
// vpr_ctrl
// Sequencer of the controller: steps through the control law one datapath
// operation at a time and waits for each to finish.
// ----------------------------------------------------------------------------
module vpr_ctrl
    import vpr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_issued, n_issued;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_issued <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_issued <= n_issued;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_issued    = r_issued;
        o_in_ready  = 1'b0;
        o_cmd.load  = 1'b0;
        o_cmd.go    = 1'b0;
        o_cmd.op    = OP_ADD;
        o_cmd.src_a = SRC_E;
        o_cmd.src_b = SRC_E;
        o_cmd.dst   = DST_T0;

        case (r_state)
            ST_IDLE: begin
            end
            ST_MUL_P: begin
                o_cmd.op = OP_MUL; o_cmd.src_a = SRC_GP; o_cmd.src_b = SRC_E;
                o_cmd.dst = DST_P;
            end
            ST_ADD_S: begin
                o_cmd.op = OP_ADD; o_cmd.src_a = SRC_E; o_cmd.src_b = SRC_LE;
                o_cmd.dst = DST_T0;
            end
            ST_MUL_H: begin
                o_cmd.op = OP_MUL; o_cmd.src_a = SRC_T0; o_cmd.src_b = SRC_HALF;
                o_cmd.dst = DST_T0;
            end
            ST_MUL_K: begin
                o_cmd.op = OP_MUL; o_cmd.src_a = SRC_GI; o_cmd.src_b = SRC_SP;
                o_cmd.dst = DST_T1;
            end
            ST_MUL_I: begin
                o_cmd.op = OP_MUL; o_cmd.src_a = SRC_T1; o_cmd.src_b = SRC_T0;
                o_cmd.dst = DST_T0;
            end
            ST_ADD_I: begin
                o_cmd.op = OP_ADD; o_cmd.src_a = SRC_IS; o_cmd.src_b = SRC_T0;
                o_cmd.dst = DST_IS;
            end
            ST_CLP_I: begin
                o_cmd.op = OP_CLAMP; o_cmd.src_a = SRC_IS; o_cmd.dst = DST_IS;
            end
            ST_SUB_D: begin
                o_cmd.op = OP_SUB; o_cmd.src_a = SRC_E; o_cmd.src_b = SRC_LE;
                o_cmd.dst = DST_T0;
            end
            ST_MUL_D: begin
                o_cmd.op = OP_MUL; o_cmd.src_a = SRC_GD; o_cmd.src_b = SRC_T0;
                o_cmd.dst = DST_T0;
            end
            ST_DIV_D: begin
                o_cmd.op = OP_DIV; o_cmd.src_a = SRC_T0; o_cmd.src_b = SRC_SP;
                o_cmd.dst = DST_T0;
            end
            ST_ADD_1: begin
                o_cmd.op = OP_ADD; o_cmd.src_a = SRC_P; o_cmd.src_b = SRC_IS;
                o_cmd.dst = DST_T1;
            end
            ST_ADD_2: begin
                o_cmd.op = OP_ADD; o_cmd.src_a = SRC_T1; o_cmd.src_b = SRC_T0;
                o_cmd.dst = DST_DRV;
            end
            ST_CLP_O: begin
                o_cmd.op = OP_CLAMP; o_cmd.src_a = SRC_DRV; o_cmd.dst = DST_DRV;
            end
            ST_SUB_R: begin
                o_cmd.op = OP_SUB; o_cmd.src_a = SRC_DRV; o_cmd.src_b = SRC_LD;
                o_cmd.dst = DST_T0;
            end
            ST_DIV_R: begin
                o_cmd.op = OP_DIV; o_cmd.src_a = SRC_T0; o_cmd.src_b = SRC_SP;
                o_cmd.dst = DST_T0;
            end
            ST_MUL_R: begin
                o_cmd.op = OP_MUL; o_cmd.src_a = SRC_RAMP; o_cmd.src_b = SRC_SP;
                o_cmd.dst = DST_T1;
            end
            ST_RAMP: begin
                o_cmd.op = OP_RAMP; o_cmd.src_a = SRC_T0; o_cmd.src_b = SRC_T1;
                o_cmd.dst = DST_DRV;
            end
            ST_COMMIT: begin
                o_cmd.op = OP_COMMIT;
            end
            default: begin
            end
        endcase

        if (r_state == ST_IDLE) begin
            o_in_ready = 1'b1;
            if (i_in_valid) begin
                o_cmd.load = 1'b1;
                n_state    = ST_MUL_P;
            end
        end else if (r_issued) begin
            if (i_stat.done) begin
                n_issued = 1'b0;
                case (r_state)
                    ST_MUL_P: n_state = ST_ADD_S;
                    ST_ADD_S: n_state = ST_MUL_H;
                    ST_MUL_H: n_state = ST_MUL_K;
                    ST_MUL_K: n_state = ST_MUL_I;
                    ST_MUL_I: n_state = ST_ADD_I;
                    ST_ADD_I: n_state = ST_CLP_I;
                    ST_CLP_I: n_state = ST_SUB_D;
                    ST_SUB_D: n_state = ST_MUL_D;
                    ST_MUL_D: n_state = ST_DIV_D;
                    ST_DIV_D: n_state = ST_ADD_1;
                    ST_ADD_1: n_state = ST_ADD_2;
                    ST_ADD_2: n_state = ST_CLP_O;
                    ST_CLP_O: n_state = i_stat.is_voltage ? ST_SUB_R : ST_COMMIT;
                    ST_SUB_R: n_state = ST_DIV_R;
                    ST_DIV_R: n_state = ST_MUL_R;
                    ST_MUL_R: n_state = ST_RAMP;
                    ST_RAMP:  n_state = ST_COMMIT;
                    ST_COMMIT: n_state = ST_IDLE;
                    default:  n_state = ST_IDLE;
                endcase
            end
        end else if (r_state != ST_COMMIT || i_stat.out_free) begin
            o_cmd.go = 1'b1;
            n_issued = 1'b1;
        end
    end

endmodule

@@ rtl/vpr_dp.sv @@
// ----------------------------------------------------------------------------
// vpr_dp
// Datapath: working registers, a combinational saturating ALU, a shift-add
// multiplier, a restoring divider and the output register.
// ----------------------------------------------------------------------------
module vpr_dp
    import vpr_pkg::*;
#(
    parameter int WORD_WIDTH = DEF_WORD_WIDTH,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cmd                         i_cmd,
    output t_stat                        o_stat,
    input  logic signed [WORD_WIDTH-1:0] i_speed_error,
    input  logic                         i_clear_history,
    input  logic signed [WORD_WIDTH-1:0] i_gain_p,
    input  logic signed [WORD_WIDTH-1:0] i_gain_i,
    input  logic signed [WORD_WIDTH-1:0] i_gain_d,
    input  logic [WORD_WIDTH-2:0]        i_sample_period,
    input  logic [WORD_WIDTH-2:0]        i_voltage_limit,
    input  logic [WORD_WIDTH-2:0]        i_current_limit,
    input  logic [WORD_WIDTH-2:0]        i_ramp_rate,
    input  logic [1:0]                   i_torque_mode,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic signed [WORD_WIDTH-1:0] o_drive_value
);

    localparam int W  = WORD_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int QW = W + F;
    localparam int PW = 2 * W + F + 1;
    localparam int CW = $clog2(QW + 1);
    localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] HALF = {{(W-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
    localparam logic [PW-1:0] POS_LIM = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic [PW-1:0] NEG_LIM = {{(PW-W){1'b0}}, 1'b1, {(W-1){1'b0}}};

    logic signed [W-1:0] r_e, r_le, r_is, r_ld, r_p, r_t0, r_t1, r_drv, r_out;
    logic                r_out_valid, r_done, r_busy, r_fin, r_div;
    logic [CW-1:0]       r_cnt;
    logic                r_neg, r_a_neg, r_nz, r_dz;
    logic [W-1:0]        r_ma;
    logic [2*W-1:0]      r_acc;
    logic [QW-1:0]       r_q;
    logic [W-1:0]        r_rem;
    t_dst                r_dst;

    function automatic logic signed [W-1:0] sat_w(input logic signed [W:0] v);
        if (v[W] != v[W-1]) begin
            return v[W] ? WMIN : WMAX;
        end
        return v[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
                                                    input logic signed [W-1:0] b);
        return sat_w({a[W-1], a} + {b[W-1], b});
    endfunction

    function automatic logic signed [W-1:0] sat_sub(input logic signed [W-1:0] a,
                                                    input logic signed [W-1:0] b);
        return sat_w({a[W-1], a} - {b[W-1], b});
    endfunction

    function automatic logic [W-1:0] mag(input logic signed [W-1:0] x);
        return x[W-1] ? (~x + 1'b1) : x;
    endfunction

    function automatic logic signed [W-1:0] pack(input logic neg, input logic [PW-1:0] m);
        if (neg) begin
            if (m > NEG_LIM) begin
                return WMIN;
            end
            return ~m[W-1:0] + 1'b1;
        end
        if (m > POS_LIM) begin
            return WMAX;
        end
        return m[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] clamp_sym(input logic signed [W-1:0] v,
                                                      input logic [W-2:0] lim);
        logic signed [W-1:0] hi;
        logic signed [W-1:0] lo;
        hi = {1'b0, lim};
        lo = -hi;
        if (v > hi) begin
            return hi;
        end
        if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

    function automatic logic signed [W-1:0] pick(input t_src s);
        case (s)
            SRC_E:    return r_e;
            SRC_LE:   return r_le;
            SRC_IS:   return r_is;
            SRC_LD:   return r_ld;
            SRC_P:    return r_p;
            SRC_T0:   return r_t0;
            SRC_T1:   return r_t1;
            SRC_DRV:  return r_drv;
            SRC_GP:   return i_gain_p;
            SRC_GI:   return i_gain_i;
            SRC_GD:   return i_gain_d;
            SRC_SP:   return {1'b0, i_sample_period};
            SRC_RAMP: return {1'b0, i_ramp_rate};
            SRC_HALF: return HALF;
            default:  return '0;
        endcase
    endfunction

    logic signed [W-1:0] a_op, b_op, alu_res, unit_res, wr_data, ramp_s;
    logic                wr_en, single_op, div_ge;
    t_dst                wr_sel;
    logic [W:0]          mul_sum, div_t, div_sub;
    logic [2*W:0]        mul_rnd;
    logic [QW:0]         q_rnd;

    // Operand selection reads the working registers, so it has to follow them.
    always_comb begin
        a_op = pick(i_cmd.src_a);
        b_op = pick(i_cmd.src_b);
    end

    assign single_op = (i_cmd.op == OP_ADD) || (i_cmd.op == OP_SUB) ||
                       (i_cmd.op == OP_CLAMP) || (i_cmd.op == OP_RAMP);
    assign ramp_s    = {1'b0, i_ramp_rate};

    always_comb begin
        case (i_cmd.op)
            OP_ADD: alu_res = sat_add(a_op, b_op);
            OP_SUB: alu_res = sat_sub(a_op, b_op);
            OP_CLAMP: begin
                if (i_torque_mode == MODE_VOLTAGE) begin
                    alu_res = clamp_sym(a_op, i_voltage_limit);
                end else if (i_torque_mode == MODE_CURRENT) begin
                    alu_res = clamp_sym(a_op, i_current_limit);
                end else begin
                    alu_res = a_op;
                end
            end
            OP_RAMP: begin
                // Operand a is the rate of change, b the largest step.
                if (a_op > ramp_s) begin
                    alu_res = sat_add(r_ld, b_op);
                end else if (a_op < -ramp_s) begin
                    alu_res = sat_sub(r_ld, b_op);
                end else begin
                    alu_res = r_drv;
                end
            end
            default: alu_res = a_op;
        endcase
    end

    // Iteration logic of the shared multiplier and divider.
    assign mul_sum = {1'b0, r_acc[2*W-1:W]} + (r_acc[0] ? {1'b0, r_ma} : '0);
    assign div_t   = {r_rem, r_q[QW-1]};
    assign div_ge  = div_t >= {1'b0, r_ma};
    assign div_sub = div_t - {1'b0, r_ma};
    assign mul_rnd = {1'b0, r_acc} + {{(2*W+1-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
    assign q_rnd   = {1'b0, r_q} + {{QW{1'b0}}, ({r_rem, 1'b0} >= {1'b0, r_ma})};

    always_comb begin
        if (!r_div) begin
            unit_res = pack(r_neg, {{(PW-(2*W+1-F)){1'b0}}, mul_rnd[2*W:F]});
        end else if (r_dz) begin
            unit_res = r_nz ? (r_a_neg ? WMIN : WMAX) : '0;
        end else begin
            unit_res = pack(r_neg, {{(PW-QW-1){1'b0}}, q_rnd});
        end
    end

    assign wr_en   = r_fin || (i_cmd.go && single_op);
    assign wr_sel  = r_fin ? r_dst : i_cmd.dst;
    assign wr_data = r_fin ? unit_res : alu_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_le        <= '0;
            r_is        <= '0;
            r_ld        <= '0;
            r_out_valid <= 1'b0;
            r_done      <= 1'b0;
            r_busy      <= 1'b0;
            r_fin       <= 1'b0;
        end else begin
            r_done <= r_fin || (i_cmd.go && (single_op || (i_cmd.op == OP_COMMIT)));
            r_fin  <= r_busy && (r_cnt == '0);
            if (i_cmd.go && (i_cmd.op == OP_COMMIT)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.load) begin
                r_e <= i_speed_error;
                if (i_clear_history) begin
                    r_le <= '0;
                    r_is <= '0;
                    r_ld <= '0;
                end
            end
            if (wr_en) begin
                case (wr_sel)
                    DST_IS:  r_is  <= wr_data;
                    DST_P:   r_p   <= wr_data;
                    DST_T0:  r_t0  <= wr_data;
                    DST_T1:  r_t1  <= wr_data;
                    DST_DRV: r_drv <= wr_data;
                    default: r_t0  <= wr_data;
                endcase
            end
            if (i_cmd.go) begin
                case (i_cmd.op)
                    OP_MUL: begin
                        r_busy <= 1'b1;
                        r_div  <= 1'b0;
                        r_cnt  <= CW'(W - 1);
                        r_neg  <= a_op[W-1] ^ b_op[W-1];
                        r_ma   <= mag(a_op);
                        r_acc  <= {{W{1'b0}}, mag(b_op)};
                        r_dst  <= i_cmd.dst;
                    end
                    OP_DIV: begin
                        r_busy  <= 1'b1;
                        r_div   <= 1'b1;
                        r_cnt   <= CW'(QW - 1);
                        r_neg   <= a_op[W-1] ^ b_op[W-1];
                        r_a_neg <= a_op[W-1];
                        r_nz    <= (a_op != '0);
                        r_dz    <= (b_op == '0);
                        r_ma    <= mag(b_op);
                        r_q     <= {mag(a_op), {F{1'b0}}};
                        r_rem   <= '0;
                        r_dst   <= i_cmd.dst;
                    end
                    OP_COMMIT: begin
                        r_le  <= r_e;
                        r_ld  <= r_drv;
                        r_out <= r_drv;
                    end
                    default: begin
                    end
                endcase
            end
            if (r_busy) begin
                if (r_div) begin
                    r_rem <= div_ge ? div_sub[W-1:0] : div_t[W-1:0];
                    r_q   <= {r_q[QW-2:0], div_ge};
                end else begin
                    r_acc <= {mul_sum, r_acc[W-1:1]};
                end
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_stat.done       = r_done;
    assign o_stat.out_free   = !r_out_valid || i_out_ready;
    assign o_stat.is_voltage = (i_torque_mode == MODE_VOLTAGE);
    assign o_out_valid       = r_out_valid;
    assign o_drive_value     = r_out;

endmodule

@@ rtl/velocity_pid_ramp_controller.sv @@
// ----------------------------------------------------------------------------
// velocity_pid_ramp_controller
// Velocity PID with trapezoidal integral, anti-windup clamp and output ramp
// in signed fixed point, with an APB-style register port.
// ----------------------------------------------------------------------------
// One speed error is taken per transfer and one drive value is returned per
// transfer. All operations run one after another on a single shift-add
// multiplier, a restoring divider and a saturating ALU; voltage mode also
// runs the output ramp. The result sits in an output register, so the next
// input transfer is taken while it waits. The user must see that registers
// are written only while the block is idle; the block itself does not
// enforce this. Register i lies at byte address 8*i.
// ----------------------------------------------------------------------------
module velocity_pid_ramp_controller
    import vpr_pkg::*;
#(
    parameter int WORD_WIDTH = DEF_WORD_WIDTH,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Input channel.
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [WORD_WIDTH-1:0] i_speed_error,
    input  logic                         i_clear_history,
    // Output channel.
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [WORD_WIDTH-1:0] o_drive_value,
    // Register port.
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [CFG_ADDR_W-1:0]        paddr,
    input  logic [CFG_DATA_W-1:0]        pwdata,
    output logic [CFG_DATA_W-1:0]        prdata,
    output logic                         pready
);

    localparam int W = WORD_WIDTH;
    // One millisecond in the chosen format, rounded to nearest.
    localparam logic [63:0] SP_RESET = ((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000;

    logic signed [W-1:0] r_gain_p, r_gain_i, r_gain_d;
    logic [W-2:0]        r_sample_period, r_voltage_limit, r_current_limit, r_ramp_rate;
    logic [1:0]          r_torque_mode;
    logic                cfg_wr;
    logic [2:0]          cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p        <= '0;
            r_gain_i        <= '0;
            r_gain_d        <= '0;
            r_sample_period <= SP_RESET[W-2:0];
            r_voltage_limit <= '0;
            r_current_limit <= '0;
            r_ramp_rate     <= '0;
            r_torque_mode   <= MODE_VOLTAGE;
        end else if (cfg_wr) begin
            case (cfg_idx)
                CFG_GAIN_P:        r_gain_p        <= pwdata[W-1:0];
                CFG_GAIN_I:        r_gain_i        <= pwdata[W-1:0];
                CFG_GAIN_D:        r_gain_d        <= pwdata[W-1:0];
                CFG_SAMPLE_PERIOD: r_sample_period <= pwdata[W-2:0];
                CFG_VOLTAGE_LIMIT: r_voltage_limit <= pwdata[W-2:0];
                CFG_CURRENT_LIMIT: r_current_limit <= pwdata[W-2:0];
                CFG_RAMP_RATE:     r_ramp_rate     <= pwdata[W-2:0];
                CFG_TORQUE_MODE:   r_torque_mode   <= pwdata[1:0];
                default: begin
                end
            endcase
        end
    end

    // Read data: signed gains are sign-extended, the rest zero-extended.
    always_comb begin
        case (cfg_idx)
            CFG_GAIN_P:        prdata = CFG_DATA_W'(r_gain_p);
            CFG_GAIN_I:        prdata = CFG_DATA_W'(r_gain_i);
            CFG_GAIN_D:        prdata = CFG_DATA_W'(r_gain_d);
            CFG_SAMPLE_PERIOD: prdata = CFG_DATA_W'(r_sample_period);
            CFG_VOLTAGE_LIMIT: prdata = CFG_DATA_W'(r_voltage_limit);
            CFG_CURRENT_LIMIT: prdata = CFG_DATA_W'(r_current_limit);
            CFG_RAMP_RATE:     prdata = CFG_DATA_W'(r_ramp_rate);
            CFG_TORQUE_MODE:   prdata = CFG_DATA_W'(r_torque_mode);
            default:           prdata = '0;
        endcase
    end

    t_cmd  cmd;
    t_stat stat;

    vpr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .o_in_ready (o_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    vpr_dp #(
        .WORD_WIDTH (WORD_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_speed_error   (i_speed_error),
        .i_clear_history (i_clear_history),
        .i_gain_p        (r_gain_p),
        .i_gain_i        (r_gain_i),
        .i_gain_d        (r_gain_d),
        .i_sample_period (r_sample_period),
        .i_voltage_limit (r_voltage_limit),
        .i_current_limit (r_current_limit),
        .i_ramp_rate     (r_ramp_rate),
        .i_torque_mode   (r_torque_mode),
        .i_out_ready     (i_ready),
        .o_out_valid     (o_valid),
        .o_drive_value   (o_drive_value)
    );

endmodule
